/* hdl/ssrp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssrp_pkg
// Shared constants, codes and controller/datapath types of the skyline packer.
// ----------------------------------------------------------------------------
package ssrp_pkg;

    localparam int MAX_RECTS = 64;
    localparam int SIZE_BITS = 12;
    localparam int IDX_W     = $clog2(MAX_RECTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SKY_AW    = IDX_W + 1;
    localparam int LEN_W     = SKY_AW + 1;
    localparam int XW        = 13;
    localparam int YW        = 18;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NARROW   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    localparam logic [XW-1:0] ATLAS_RESET = XW'(512);

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ENTRY, OP_RK_RD, OP_RK_LD, OP_RK_SWEEP, OP_RK_WR,
        OP_PK_INIT, OP_PK_RD_ORD, OP_PK_RD_SIZE, OP_PK_GET, OP_PK_CHECK,
        OP_PK_Y0, OP_PK_Y0D, OP_PK_CMP_RD, OP_PK_CMP, OP_PK_YN, OP_PK_PLACE,
        OP_PK_PLACE2, OP_OUT_RD, OP_OUT_EMIT, OP_FAIL1, OP_FAIL2
    } t_op;

    typedef struct packed {
        logic fail2;
        logic j_end;
        logic cmpv;
        logic i_last;
        logic fit_fail;
        logic wide_fail;
        logic bound_ok;
        logic cmp_hit;
    } t_sts;

endpackage
`default_nettype wire

/* hdl/serpentine_skyline_rect_packer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// serpentine_skyline_rect_packer_unit
// Loads rectangle sizes, sorts them and packs them in serpentine skyline rows.
// ----------------------------------------------------------------------------
// Loading takes one rectangle per cycle while busy is low. The request marked
// last keeps busy high while the set is ranked (one size store read per
// compare), placed (with a compare loop over each skyline step spanned) and
// emitted, each result read from the offset store and then shown for a single
// cycle on o_result_valid; the receiver cannot stall. Configuration writes are
// taken only while busy is low.
module serpentine_skyline_rect_packer_unit import ssrp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [SIZE_BITS-1:0] i_rect_width,
    input  wire logic [SIZE_BITS-1:0] i_rect_height,
    input  wire logic                 i_last_rect,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [XW-1:0]        i_cfg_data,
    output logic                      o_result_valid,
    output logic [IDX_W-1:0]          o_rect_index,
    output logic [XW-1:0]             o_x_pos,
    output logic [YW-1:0]             o_y_pos,
    output logic [YW-1:0]             o_pack_height,
    output logic [1:0]                o_status,
    output logic                      o_last_result
);

    t_op  op;
    t_sts sts;

    assign o_cfg_ready = !busy;

    ssrp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_last_rect (i_last_rect),
        .i_sts       (sts),
        .o_op        (op),
        .busy        (busy)
    );

    ssrp_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_last_rect    (i_last_rect),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_rect_index   (o_rect_index),
        .o_x_pos        (o_x_pos),
        .o_y_pos        (o_y_pos),
        .o_pack_height  (o_pack_height),
        .o_status       (o_status),
        .o_last_result  (o_last_result)
    );

endmodule
`default_nettype wire

/* hdl/ssrp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssrp_ctrl
// Sequencer for loading, rank sort, skyline placement and result output.
// ----------------------------------------------------------------------------
module ssrp_ctrl import ssrp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic i_last_rect,
    input  wire t_sts i_sts,
    output t_op       o_op,
    output logic      busy
);

    typedef enum logic [21:0] {
        S_IDLE       = 22'h000001,
        S_ENTRY      = 22'h000002,
        S_RK_RD      = 22'h000004,
        S_RK_LD      = 22'h000008,
        S_RK_SWEEP   = 22'h000010,
        S_RK_WR      = 22'h000020,
        S_PK_INIT    = 22'h000040,
        S_PK_RD_ORD  = 22'h000080,
        S_PK_RD_SIZE = 22'h000100,
        S_PK_GET     = 22'h000200,
        S_PK_CHECK   = 22'h000400,
        S_PK_Y0      = 22'h000800,
        S_PK_Y0D     = 22'h001000,
        S_PK_CMP_RD  = 22'h002000,
        S_PK_CMP     = 22'h004000,
        S_PK_YN      = 22'h008000,
        S_PK_PLACE   = 22'h010000,
        S_PK_PLACE2  = 22'h020000,
        S_OUT_RD     = 22'h040000,
        S_OUT_EMIT   = 22'h080000,
        S_FAIL1      = 22'h100000,
        S_FAIL2      = 22'h200000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op = OP_LOAD;
                    if (i_last_rect) n_state = S_ENTRY;
                end
            end
            S_ENTRY: begin
                o_op    = OP_ENTRY;
                n_state = i_sts.fail2 ? S_FAIL2 : S_RK_RD;
            end
            S_RK_RD: begin
                o_op    = OP_RK_RD;
                n_state = S_RK_LD;
            end
            S_RK_LD: begin
                o_op    = OP_RK_LD;
                n_state = S_RK_SWEEP;
            end
            S_RK_SWEEP: begin
                o_op = OP_RK_SWEEP;
                if (i_sts.j_end && !i_sts.cmpv) n_state = S_RK_WR;
            end
            S_RK_WR: begin
                o_op    = OP_RK_WR;
                n_state = i_sts.i_last ? S_PK_INIT : S_RK_RD;
            end
            S_PK_INIT: begin
                o_op    = OP_PK_INIT;
                n_state = S_PK_RD_ORD;
            end
            S_PK_RD_ORD: begin
                o_op    = OP_PK_RD_ORD;
                n_state = S_PK_RD_SIZE;
            end
            S_PK_RD_SIZE: begin
                o_op    = OP_PK_RD_SIZE;
                n_state = S_PK_GET;
            end
            S_PK_GET: begin
                o_op    = OP_PK_GET;
                n_state = S_PK_CHECK;
            end
            S_PK_CHECK: begin
                o_op    = OP_PK_CHECK;
                n_state = (i_sts.fit_fail && i_sts.wide_fail) ? S_FAIL1 : S_PK_Y0;
            end
            S_PK_Y0: begin
                o_op    = OP_PK_Y0;
                n_state = S_PK_Y0D;
            end
            S_PK_Y0D: begin
                o_op    = OP_PK_Y0D;
                n_state = S_PK_CMP_RD;
            end
            S_PK_CMP_RD: begin
                o_op    = OP_PK_CMP_RD;
                n_state = i_sts.bound_ok ? S_PK_CMP : S_PK_PLACE;
            end
            S_PK_CMP: begin
                o_op    = OP_PK_CMP;
                n_state = i_sts.cmp_hit ? S_PK_YN : S_PK_PLACE;
            end
            S_PK_YN: begin
                o_op    = OP_PK_YN;
                n_state = S_PK_CMP_RD;
            end
            S_PK_PLACE: begin
                o_op    = OP_PK_PLACE;
                n_state = S_PK_PLACE2;
            end
            S_PK_PLACE2: begin
                o_op    = OP_PK_PLACE2;
                n_state = i_sts.i_last ? S_OUT_RD : S_PK_RD_ORD;
            end
            S_OUT_RD: begin
                o_op    = OP_OUT_RD;
                n_state = S_OUT_EMIT;
            end
            S_OUT_EMIT: begin
                o_op    = OP_OUT_EMIT;
                n_state = i_sts.i_last ? S_IDLE : S_OUT_RD;
            end
            S_FAIL1: begin
                o_op    = OP_FAIL1;
                n_state = S_IDLE;
            end
            S_FAIL2: begin
                o_op    = OP_FAIL2;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/ssrp_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ssrp_dpath
// Size, order, skyline and offset stores with the sort and placement datapath.
// ----------------------------------------------------------------------------
module ssrp_dpath import ssrp_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_op                  i_op,
    input  wire logic                 i_cfg_we,
    input  wire logic [XW-1:0]        i_cfg_data,
    input  wire logic [SIZE_BITS-1:0] i_rect_width,
    input  wire logic [SIZE_BITS-1:0] i_rect_height,
    input  wire logic                 i_last_rect,
    output t_sts                      o_sts,
    output logic                      o_result_valid,
    output logic [IDX_W-1:0]          o_rect_index,
    output logic [XW-1:0]             o_x_pos,
    output logic [YW-1:0]             o_y_pos,
    output logic [YW-1:0]             o_pack_height,
    output logic [1:0]                o_status,
    output logic                      o_last_result
);

    logic [2*SIZE_BITS-1:0] size_mem [MAX_RECTS];
    logic [IDX_W-1:0]       ord_mem  [MAX_RECTS];
    logic [XW+YW-1:0]       sky_mem  [2*(1<<SKY_AW)];
    logic [XW+YW-1:0]       off_mem  [MAX_RECTS];

    logic [2*SIZE_BITS-1:0] r_size_rd;
    logic [IDX_W-1:0]       r_ord_rd;
    logic [XW+YW-1:0]       r_sky_rd;
    logic [XW+YW-1:0]       r_off_rd;
    logic                   r_sk_first, r_sk_end, r_sk_virt;

    logic [XW-1:0]          r_atlas;
    logic [CNT_W-1:0]       r_count, r_n, r_i, r_j;
    logic                   r_ovf, r_fail2, r_cmpv;
    logic [IDX_W-1:0]       r_cj, r_rank, r_idx;
    logic [2*SIZE_BITS-1:0] r_key;
    logic [SIZE_BITS-1:0]   r_w, r_h;
    logic [XW-1:0]          r_x;
    logic [YW-1:0]          r_y, r_ph, r_first_top, r_last_top;
    logic [LEN_W-1:0]       r_nx, r_step, r_plen, r_rlen;
    logic                   r_ltr, r_rev, r_virt, r_bank;

    logic                   r_o_valid;
    logic [IDX_W-1:0]       r_o_index;
    logic [XW-1:0]          r_o_x;
    logic [YW-1:0]          r_o_y, r_o_ph;
    logic [1:0]             r_o_status;
    logic                   r_o_last;

    logic [IDX_W-1:0]       size_raddr;
    logic [LEN_W-1:0]       sky_log, sky_phys;
    logic [SKY_AW:0]        sky_waddr;
    logic [XW-1:0]          sky_wx;
    logic                   sky_we;
    logic [XW-1:0]          sky_x;
    logic [YW-1:0]          sky_y;
    logic [SIZE_BITS-1:0]   kw, kh, sw, sh;
    logic                   ranks_ahead;
    logic [XW:0]            x_plus_w;
    logic [XW-1:0]          x_minus_w;
    logic [YW-1:0]          top;
    logic                   ltr_new;
    logic [CNT_W-1:0]       count_inc;

    assign kw = r_key[SIZE_BITS-1:0];
    assign kh = r_key[2*SIZE_BITS-1:SIZE_BITS];
    assign sw = r_size_rd[SIZE_BITS-1:0];
    assign sh = r_size_rd[2*SIZE_BITS-1:SIZE_BITS];
    assign ranks_ahead = (sh > kh) || ((sh == kh) && ((sw > kw) ||
                         ((sw == kw) && (r_cj < r_i[IDX_W-1:0]))));

    assign x_plus_w  = {1'b0, r_x} + (XW+1)'(r_w);
    assign x_minus_w = r_x - XW'(r_w);
    assign top       = r_y + YW'(r_h);
    assign ltr_new   = r_ltr ? (r_first_top < r_last_top) : (r_last_top < r_first_top);
    assign count_inc = r_count + 1'b1;

    assign sky_x = r_sk_first ? '0 : (r_sk_end ? r_atlas : r_sky_rd[XW+YW-1:YW]);
    assign sky_y = r_sk_virt ? '0 : r_sky_rd[YW-1:0];

    always_comb begin
        size_raddr = r_i[IDX_W-1:0];
        case (i_op)
            OP_RK_SWEEP:   size_raddr = r_j[IDX_W-1:0];
            OP_PK_RD_SIZE: size_raddr = r_ord_rd;
            default:       size_raddr = r_i[IDX_W-1:0];
        endcase
    end

    always_comb begin
        sky_log = r_step;
        case (i_op)
            OP_PK_Y0:     sky_log = r_ltr ? r_step : r_step + 1'b1;
            OP_PK_CMP_RD: sky_log = r_ltr ? r_nx + 1'b1 : r_nx;
            OP_PK_CMP:    sky_log = r_ltr ? r_nx + LEN_W'(2) : r_nx - 1'b1;
            default:      sky_log = r_step;
        endcase
        sky_phys = r_rev ? (r_plen - 1'b1 - sky_log) : sky_log;
    end

    always_comb begin
        sky_we    = 1'b0;
        sky_waddr = {~r_bank, r_rlen[SKY_AW-1:0]};
        sky_wx    = r_x;
        case (i_op)
            OP_PK_PLACE: begin
                sky_we = 1'b1;
            end
            OP_PK_PLACE2: begin
                sky_we    = 1'b1;
                sky_waddr = {~r_bank, SKY_AW'(r_rlen + 1'b1)};
                sky_wx    = r_ltr ? x_plus_w[XW-1:0] : x_minus_w;
            end
            default: begin
                sky_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_size_rd  <= size_mem[size_raddr];
        r_ord_rd   <= ord_mem[r_i[IDX_W-1:0]];
        r_off_rd   <= off_mem[r_i[IDX_W-1:0]];
        r_sky_rd   <= sky_mem[{r_bank, sky_phys[SKY_AW-1:0]}];
        r_sk_first <= (sky_log == '0);
        r_sk_end   <= (sky_log == r_plen - 1'b1);
        r_sk_virt  <= r_virt;
        if (i_op == OP_LOAD && r_count < CNT_W'(MAX_RECTS)) begin
            size_mem[r_count[IDX_W-1:0]] <= {i_rect_height, i_rect_width};
        end
        if (i_op == OP_RK_WR) begin
            ord_mem[r_rank] <= r_i[IDX_W-1:0];
        end
        if (i_op == OP_PK_PLACE) begin
            off_mem[r_idx] <= {(r_ltr ? r_x : x_minus_w), r_y};
        end
        if (sky_we) begin
            sky_mem[sky_waddr] <= {sky_wx, top};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas   <= ATLAS_RESET;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (i_cfg_we) r_atlas <= i_cfg_data;
            case (i_op)
                OP_LOAD: begin
                    if (i_last_rect) begin
                        r_n     <= (r_count < CNT_W'(MAX_RECTS)) ? count_inc : r_count;
                        r_fail2 <= r_ovf || (r_count == CNT_W'(MAX_RECTS));
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                    end else if (r_count < CNT_W'(MAX_RECTS)) begin
                        r_count <= count_inc;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                OP_ENTRY: begin
                    r_i <= '0;
                end
                OP_RK_LD: begin
                    r_key  <= r_size_rd;
                    r_rank <= '0;
                    r_j    <= '0;
                    r_cmpv <= 1'b0;
                end
                OP_RK_SWEEP: begin
                    if (r_cmpv && ranks_ahead) r_rank <= r_rank + 1'b1;
                    if (r_j < r_n) begin
                        r_j    <= r_j + 1'b1;
                        r_cj   <= r_j[IDX_W-1:0];
                        r_cmpv <= 1'b1;
                    end else begin
                        r_cmpv <= 1'b0;
                    end
                end
                OP_RK_WR: begin
                    r_i <= o_sts.i_last ? '0 : r_i + 1'b1;
                end
                OP_PK_INIT: begin
                    r_x    <= '0;
                    r_ph   <= '0;
                    r_plen <= LEN_W'(2);
                    r_rlen <= '0;
                    r_step <= '0;
                    r_ltr  <= 1'b1;
                    r_rev  <= 1'b0;
                    r_virt <= 1'b1;
                    r_bank <= 1'b0;
                end
                OP_PK_RD_SIZE: begin
                    r_idx <= r_ord_rd;
                end
                OP_PK_GET: begin
                    r_w <= sw;
                    r_h <= sh;
                end
                OP_PK_CHECK: begin
                    if (o_sts.fit_fail && !o_sts.wide_fail) begin
                        r_plen <= r_rlen;
                        r_rlen <= '0;
                        r_rev  <= !r_ltr;
                        r_virt <= 1'b0;
                        r_bank <= !r_bank;
                        r_ltr  <= ltr_new;
                        r_x    <= ltr_new ? '0 : r_atlas;
                        r_step <= ltr_new ? '0 : r_rlen - LEN_W'(2);
                    end
                end
                OP_PK_Y0: begin
                    r_nx <= r_step;
                end
                OP_PK_Y0D: begin
                    r_y <= sky_y;
                end
                OP_PK_CMP: begin
                    if (o_sts.cmp_hit) r_nx <= r_ltr ? r_nx + LEN_W'(2) : r_nx - LEN_W'(2);
                end
                OP_PK_YN: begin
                    if (sky_y > r_y) r_y <= sky_y;
                end
                OP_PK_PLACE: begin
                    if (r_rlen == '0) r_first_top <= top;
                    r_last_top <= top;
                    if (top > r_ph) r_ph <= top;
                end
                OP_PK_PLACE2: begin
                    r_x    <= r_ltr ? x_plus_w[XW-1:0] : x_minus_w;
                    r_rlen <= r_rlen + LEN_W'(2);
                    r_step <= r_nx;
                    r_i    <= o_sts.i_last ? '0 : r_i + 1'b1;
                end
                OP_OUT_EMIT: begin
                    r_o_valid  <= 1'b1;
                    r_o_index  <= r_i[IDX_W-1:0];
                    r_o_x      <= r_off_rd[XW+YW-1:YW];
                    r_o_y      <= r_off_rd[YW-1:0];
                    r_o_ph     <= r_ph;
                    r_o_status <= ST_OK;
                    r_o_last   <= o_sts.i_last;
                    r_i        <= r_i + 1'b1;
                end
                OP_FAIL1, OP_FAIL2: begin
                    r_o_valid  <= 1'b1;
                    r_o_index  <= '0;
                    r_o_x      <= '0;
                    r_o_y      <= '0;
                    r_o_ph     <= '0;
                    r_o_status <= (i_op == OP_FAIL1) ? ST_NARROW : ST_OVERFLOW;
                    r_o_last   <= 1'b1;
                end
                default: begin
                    r_o_valid <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.fail2     = r_fail2;
        o_sts.j_end     = (r_j == r_n);
        o_sts.cmpv      = r_cmpv;
        o_sts.i_last    = (r_i + 1'b1 == r_n);
        o_sts.fit_fail  = r_ltr ? (x_plus_w > {1'b0, r_atlas}) : ({1'b0, r_w} > {1'b0, r_x});
        o_sts.wide_fail = (r_rlen < LEN_W'(2)) || ({1'b0, r_w} > {1'b0, r_atlas});
        o_sts.bound_ok  = r_ltr ? ((r_nx + LEN_W'(3)) < r_plen) : (r_nx >= LEN_W'(2));
        o_sts.cmp_hit   = r_ltr ? (x_plus_w > {1'b0, sky_x}) : (x_minus_w < sky_x);
    end

    assign o_result_valid = r_o_valid;
    assign o_rect_index   = r_o_index;
    assign o_x_pos        = r_o_x;
    assign o_y_pos        = r_o_y;
    assign o_pack_height  = r_o_ph;
    assign o_status       = r_o_status;
    assign o_last_result  = r_o_last;

endmodule
`default_nettype wire

/* verif/serpentine_skyline_rect_packer_unit_test.sv */
// ----------------------------------------------------------------------------
// serpentine_skyline_rect_packer_unit_test
// Loads rectangle sets into the packer under several atlas widths and checks
// every placement, failure code and pack height against an in-bench packer.
// ----------------------------------------------------------------------------
module serpentine_skyline_rect_packer_unit_test;
    import ssrp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [XW-1:0]    x;
        logic [YW-1:0]    y;
        logic [YW-1:0]    ph;
        logic [1:0]       st;
        logic             last;
    } t_placement;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [SIZE_BITS-1:0] i_rect_width = '0;
    logic [SIZE_BITS-1:0] i_rect_height = '0;
    logic                 i_last_rect = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [XW-1:0]        i_cfg_data = '0;
    logic                 o_result_valid;
    logic [IDX_W-1:0]     o_rect_index;
    logic [XW-1:0]        o_x_pos;
    logic [YW-1:0]        o_y_pos;
    logic [YW-1:0]        o_pack_height;
    logic [1:0]           o_status;
    logic                 o_last_result;

    t_placement  placements_due[$];
    int unsigned atlas_w = 512;
    int unsigned held_w[MAX_RECTS];
    int unsigned held_h[MAX_RECTS];
    int unsigned held_count = 0;
    bit          overflowed = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned rects_sent = 0;
    bit          idle_on = 1;

    serpentine_skyline_rect_packer_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_rect_width(i_rect_width), .i_rect_height(i_rect_height),
        .i_last_rect(i_last_rect), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .o_result_valid(o_result_valid), .o_rect_index(o_rect_index),
        .o_x_pos(o_x_pos), .o_y_pos(o_y_pos), .o_pack_height(o_pack_height),
        .o_status(o_status), .o_last_result(o_last_result)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_placement failure_of(logic [1:0] st);
        t_placement p;
        p.idx = '0; p.x = '0; p.y = '0; p.ph = '0; p.st = st; p.last = 1'b1;
        return p;
    endfunction

    // Sort held set, pack in serpentine rows and queue placements in load order.
    function automatic void pack_held_set(int unsigned n);
        int unsigned ord[MAX_RECTS];
        int unsigned px[2*MAX_RECTS], py[2*MAX_RECTS];
        int unsigned rx[2*MAX_RECTS], ry[2*MAX_RECTS];
        int unsigned ox[MAX_RECTS], oy[MAX_RECTS];
        int unsigned wd, plen, rlen, step, x, ph, i, j, k, nx, id, w, h, y, v, t;
        bit ltr, ahead;
        t_placement p;
        wd = atlas_w; plen = 2; rlen = 0; step = 0; x = 0; ph = 0; ltr = 1;
        for (i = 0; i < n; i++) ord[i] = i;
        for (i = 1; i < n; i++) begin
            v = ord[i];
            j = i;
            while (j > 0) begin
                id = ord[j-1];
                if (held_h[v] != held_h[id]) ahead = held_h[v] > held_h[id];
                else if (held_w[v] != held_w[id]) ahead = held_w[v] > held_w[id];
                else ahead = v < id;
                if (!ahead) break;
                ord[j] = id;
                j--;
            end
            ord[j] = v;
        end
        px[0] = 0; py[0] = 0; px[1] = wd; py[1] = 0;
        for (i = 0; i < n; i++) begin
            id = ord[i];
            w = held_w[id];
            h = held_h[id];
            if (ltr ? (x + w > wd) : (w > x)) begin
                if (rlen < 2 || w > wd) begin
                    placements_due = {placements_due, failure_of(ST_NARROW)};
                    return;
                end
                if (!ltr) begin
                    for (k = 0; k < rlen / 2; k++) begin
                        t = rx[k]; rx[k] = rx[rlen-1-k]; rx[rlen-1-k] = t;
                        t = ry[k]; ry[k] = ry[rlen-1-k]; ry[rlen-1-k] = t;
                    end
                end
                for (k = 0; k < rlen; k++) begin
                    px[k] = rx[k]; py[k] = ry[k];
                end
                plen = rlen;
                rlen = 0;
                px[0] = 0;
                px[plen-1] = wd;
                ltr = py[0] < py[plen-1];
                x = ltr ? 0 : wd;
                step = ltr ? 0 : plen - 2;
            end
            if (ltr) begin
                y = py[step];
                nx = step;
                while (x + w > px[nx+1] && nx + 3 < plen) begin
                    nx += 2;
                    if (py[nx] > y) y = py[nx];
                end
                ox[id] = x; oy[id] = y;
                rx[rlen] = x; ry[rlen] = y + h;
                rx[rlen+1] = x + w; ry[rlen+1] = y + h;
                x += w;
            end else begin
                y = py[step+1];
                nx = step;
                while (x - w < px[nx] && nx >= 2) begin
                    nx -= 2;
                    if (py[nx+1] > y) y = py[nx+1];
                end
                ox[id] = x - w; oy[id] = y;
                rx[rlen] = x; ry[rlen] = y + h;
                rx[rlen+1] = x - w; ry[rlen+1] = y + h;
                x -= w;
            end
            rlen += 2;
            step = nx;
            if (y + h > ph) ph = y + h;
        end
        for (k = 0; k < n; k++) begin
            p.idx = k[IDX_W-1:0];
            p.x = ox[k][XW-1:0];
            p.y = oy[k][YW-1:0];
            p.ph = ph[YW-1:0];
            p.st = ST_OK;
            p.last = (k + 1 == n);
            placements_due = {placements_due, p};
        end
    endfunction

    function automatic void take_rect(int unsigned w, int unsigned h, bit last);
        int unsigned n;
        if (held_count < MAX_RECTS) begin
            held_w[held_count] = w;
            held_h[held_count] = h;
            held_count++;
        end else begin
            overflowed = 1;
        end
        if (!last) return;
        n = held_count;
        held_count = 0;
        if (overflowed) begin
            overflowed = 0;
            placements_due = {placements_due, failure_of(ST_OVERFLOW)};
        end else begin
            pack_held_set(n);
        end
    endfunction

    always @(posedge i_clk) begin
        t_placement e;
        if (i_rst_n && o_result_valid) begin
            if (placements_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d x=%0d y=%0d st=%0d",
                             o_rect_index, o_x_pos, o_y_pos, o_status);
            end else begin
                e = placements_due.pop_front();
                if (o_rect_index !== e.idx || o_x_pos !== e.x || o_y_pos !== e.y ||
                    o_pack_height !== e.ph || o_status !== e.st ||
                    o_last_result !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp idx=%0d x=%0d y=%0d ph=%0d st=%0d last=%0d %s",
                                 e.idx, e.x, e.y, e.ph, e.st, e.last, "");
                    if (mismatches <= 10)
                        $display("         got idx=%0d x=%0d y=%0d ph=%0d st=%0d last=%0d",
                                 o_rect_index, o_x_pos, o_y_pos, o_pack_height,
                                 o_status, o_last_result);
                end
            end
        end
    end

    task automatic send_rect(int unsigned w, int unsigned h, bit last);
        bit taken;
        if (idle_on && $urandom_range(0, 99) < 22) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_rect_width <= w[SIZE_BITS-1:0];
        i_rect_height <= h[SIZE_BITS-1:0];
        i_last_rect <= last;
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        take_rect(w, h, last);
        rects_sent++;
    endtask

    task automatic drain;
        start <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_atlas(int unsigned w);
        bit taken;
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= w[XW-1:0];
        taken = 0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        atlas_w = w & 32'h1FFF;
    endtask

    task automatic test_directed_sets;
        send_rect(0, 0, 1);
        send_rect(4095, 4095, 1);
        send_rect(100, 50, 0);
        send_rect(200, 50, 0);
        send_rect(100, 50, 0);
        send_rect(300, 20, 1);
        set_atlas(64);
        send_rect(30, 10, 0);
        send_rect(30, 8, 0);
        send_rect(30, 5, 0);
        send_rect(30, 3, 0);
        send_rect(20, 2, 0);
        send_rect(64, 1, 1);
        set_atlas(0);
        send_rect(0, 5, 0);
        send_rect(0, 7, 1);
        send_rect(1, 1, 1);
        set_atlas(8191);
        send_rect(4095, 1, 0);
        send_rect(4095, 2, 1);
    endtask

    task automatic test_overflow;
        set_atlas(4096);
        for (int i = 0; i < MAX_RECTS; i++) send_rect(i, 64 - i, i == MAX_RECTS - 1);
        for (int i = 0; i <= MAX_RECTS; i++) send_rect(1, 1, i == MAX_RECTS);
    endtask

    task automatic test_random_sets;
        int unsigned widths[6] = '{1, 4096, 8191, 64, 200, 512};
        int unsigned n, lim, w, h, phase;
        phase = 0;
        while (rects_sent < 480) begin
            if (phase % 4 == 0)
                set_atlas(phase % 24 == 20 ? $urandom_range(0, 8191) : widths[(phase / 4) % 6]);
            idle_on = (phase % 12) < 8;
            phase++;
            n = ($urandom_range(0, 24) == 0) ? $urandom_range(65, 70) :
                ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 10);
            lim = atlas_w > 4095 ? 4095 : atlas_w;
            for (int i = 0; i < n; i++) begin
                w = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 4095) :
                    $urandom_range(0, lim / 3 + 1);
                h = ($urandom_range(0, 99) < 20) ? $urandom_range(0, 4095) :
                    $urandom_range(0, 40);
                send_rect(w, h, i == n - 1);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sets();
        test_overflow();
        test_random_sets();
        drain();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
